// ===== design/idmc_pkg.sv =====
// shared types and constants for the interval double/millisecond converter
// no dependencies; used by the interfaces and every design module

package idmc_pkg;

    // ieee-754 double layout
    localparam int unsigned FRAC_BITS = 52;
    localparam int unsigned EXP_BITS  = 11;
    localparam logic [EXP_BITS-1:0] EXP_BIAS = 11'd1023;
    // smallest exponent field that no longer fits in 32 bits
    localparam logic [EXP_BITS-1:0] EXP_SAT  = 11'd1055;

    localparam int unsigned PAT_W    = 63;
    localparam int unsigned MILLIS_W = 32;
    localparam int unsigned SH_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PATTERN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MILLIS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MILLIS  = 2'd3;

    // configuration reset values
    localparam logic [PAT_W-1:0]    RST_MIN_PATTERN = 63'h4059000000000000;
    localparam logic [PAT_W-1:0]    RST_MAX_PATTERN = 63'h414B774000000000;
    localparam logic [MILLIS_W-1:0] RST_MIN_MILLIS  = 32'd100;
    localparam logic [MILLIS_W-1:0] RST_MAX_MILLIS  = 32'd3600000;

    typedef enum logic {
        OP_D2M = 1'b0,
        OP_M2D = 1'b1
    } t_op;

    // pass: value is final; shift: value goes through the barrel shifter
    typedef enum logic {
        CLS_PASS  = 1'b0,
        CLS_SHIFT = 1'b1
    } t_cls;

    typedef struct packed {
        logic [PAT_W-1:0]    min_pattern;
        logic [PAT_W-1:0]    max_pattern;
        logic [MILLIS_W-1:0] min_millis;
        logic [MILLIS_W-1:0] max_millis;
    } t_cfg;

    // classified item between front and back
    typedef struct packed {
        t_op                 op;
        t_cls                cls;
        logic [SH_W-1:0]     sh;
        logic [MILLIS_W-1:0] val;
    } t_work;

endpackage

// ===== design/idmc_in_if.sv =====
// request channel: op select, double pattern and millisecond count
// depends on idmc_pkg for field widths

interface idmc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [63:0]                       double_in;
    logic [idmc_pkg::MILLIS_W-1:0]     millis_in;

    modport source (output valid, output op, output double_in, output millis_in,
                    input ready);
    modport sink   (input valid, input op, input double_in, input millis_in,
                    output ready);
endinterface

// ===== design/idmc_out_if.sv =====
// result channel: millisecond count and double pattern
// depends on idmc_pkg for field widths

interface idmc_out_if;
    logic                              valid;
    logic                              ready;
    logic [idmc_pkg::MILLIS_W-1:0]     millis_out;
    logic [idmc_pkg::PAT_W-1:0]        double_out;

    modport source (output valid, output millis_out, output double_out,
                    input ready);
    modport sink   (input valid, input millis_out, input double_out,
                    output ready);
endinterface

// ===== design/idmc_front.sv =====
// front end: takes request beats, clamps against the window, finds leading one
// depends on idmc_pkg and idmc_in_if

module idmc_front (
    idmc_in_if.sink               i_req,
    input  idmc_pkg::t_cfg        i_cfg,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output idmc_pkg::t_work       o_work
);

    logic [idmc_pkg::PAT_W-1:0]    pat;
    logic [idmc_pkg::EXP_BITS-1:0] expo;
    logic [idmc_pkg::EXP_BITS-1:0] e_d2m;
    logic [idmc_pkg::SH_W-1:0]     e_m2d;

    assign i_req.ready = i_q_ready;
    assign o_push      = i_req.valid && i_q_ready;

    assign pat   = i_req.double_in[idmc_pkg::PAT_W-1:0];
    assign expo  = i_req.double_in[62:52];
    assign e_d2m = expo - idmc_pkg::EXP_BIAS;

    // leading one of the millisecond count
    always_comb begin
        e_m2d = '0;
        for (int i = 0; i < idmc_pkg::MILLIS_W; i++) begin
            if (i_req.millis_in[i]) begin
                e_m2d = idmc_pkg::SH_W'(i);
            end
        end
    end

    always_comb begin
        o_work.op  = idmc_pkg::t_op'(i_req.op);
        o_work.cls = idmc_pkg::CLS_PASS;
        o_work.sh  = '0;
        o_work.val = '0;
        if (idmc_pkg::t_op'(i_req.op) == idmc_pkg::OP_M2D) begin
            // shift left by 31-e puts the leading one at bit 31
            o_work.val = i_req.millis_in;
            o_work.sh  = ~e_m2d;
            if (i_req.millis_in != '0) begin
                o_work.cls = idmc_pkg::CLS_SHIFT;
            end
        end else if (i_req.double_in[63] || pat < i_cfg.min_pattern) begin
            o_work.val = i_cfg.min_millis;
        end else if (pat > i_cfg.max_pattern) begin
            o_work.val = i_cfg.max_millis;
        end else if (expo < idmc_pkg::EXP_BIAS) begin
            o_work.val = '0;
        end else if (expo >= idmc_pkg::EXP_SAT) begin
            o_work.val = '1;
        end else begin
            // top 32 bits of the significand, shifted right by 31-e later
            o_work.cls = idmc_pkg::CLS_SHIFT;
            o_work.val = {1'b1, i_req.double_in[51:21]};
            o_work.sh  = ~e_d2m[idmc_pkg::SH_W-1:0];
        end
    end

endmodule

// ===== design/idmc_queue.sv =====
// small fifo between front and back halves
// depends on idmc_pkg for the work item type

module idmc_queue #(
    parameter int unsigned DEPTH = idmc_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  idmc_pkg::t_work   i_data,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output idmc_pkg::t_work   o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    idmc_pkg::t_work  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/idmc_back.sv =====
// back end: barrel shift and result packing into the output register
// depends on idmc_pkg and idmc_out_if

module idmc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  idmc_pkg::t_work   i_work,
    output logic              o_pop,
    idmc_out_if.source        o_rsp
);

    logic                            r_valid, n_valid;
    logic [idmc_pkg::MILLIS_W-1:0]   r_millis, n_millis;
    logic [idmc_pkg::PAT_W-1:0]      r_double, n_double;
    logic [idmc_pkg::MILLIS_W-1:0]   shl;
    logic [idmc_pkg::SH_W-1:0]       e;
    logic [idmc_pkg::EXP_BITS-1:0]   expo;

    assign o_pop = i_q_valid && (!r_valid || o_rsp.ready);

    assign shl  = i_work.val << i_work.sh;
    assign e    = ~i_work.sh;
    assign expo = idmc_pkg::EXP_BIAS + idmc_pkg::EXP_BITS'(e);

    always_comb begin
        n_millis = '0;
        n_double = '0;
        if (i_work.op == idmc_pkg::OP_D2M) begin
            n_millis = (i_work.cls == idmc_pkg::CLS_SHIFT) ? (i_work.val >> i_work.sh)
                                                           : i_work.val;
        end else if (i_work.cls == idmc_pkg::CLS_SHIFT) begin
            // leading one dropped, remaining bits fill the top of the fraction
            n_double = {expo, shl[30:0], 21'b0};
        end
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_millis <= n_millis;
            r_double <= n_double;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.millis_out = r_millis;
    assign o_rsp.double_out = r_double;

endmodule

// ===== design/interval_double_ms_converter.sv =====
// top level of the interval converter: config registers, front, queue, back
// depends on idmc_pkg, idmc_in_if, idmc_out_if, idmc_front, idmc_queue, idmc_back
//
// usage
//   i_req carries one request per beat: op 0 turns double_in (ieee-754 bits)
//   into a clamped, truncated millisecond count on millis_out; op 1 turns
//   millis_in into the exact double pattern on double_out. the field that does
//   not belong to the op reads as zero. every request gives one response beat
//   on o_rsp, in order.
//   the config port writes min_pattern, max_pattern, min_millis, max_millis
//   (index 0..3), one at a time; write only while no beat is in flight.
// throughput
//   one beat per cycle is sustained while o_rsp.ready is high: the front
//   classifies in the accepting cycle and writes the queue, the back pops
//   the item, shifts it and registers the result in the output register.
// reset and stall
//   reset empties the queue and the output register and loads the default
//   window (100.0 .. 3600000.0, 100 ms .. 3600000 ms). while o_rsp.ready is
//   low the result holds, the queue fills up to QUEUE_DEPTH beats, and then
//   i_req.ready drops.

module interval_double_ms_converter #(
    parameter int unsigned QUEUE_DEPTH = idmc_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    idmc_in_if.sink                           i_req,
    idmc_out_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [idmc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [idmc_pkg::PAT_W-1:0]        i_cfg_data
);

    idmc_pkg::t_cfg  r_cfg;
    idmc_pkg::t_work front_work;
    idmc_pkg::t_work q_work;
    logic            q_ready;
    logic            q_valid;
    logic            push;
    logic            pop;

    // config registers, written one at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pattern <= idmc_pkg::RST_MIN_PATTERN;
            r_cfg.max_pattern <= idmc_pkg::RST_MAX_PATTERN;
            r_cfg.min_millis  <= idmc_pkg::RST_MIN_MILLIS;
            r_cfg.max_millis  <= idmc_pkg::RST_MAX_MILLIS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                idmc_pkg::CFG_MIN_PATTERN: r_cfg.min_pattern <= i_cfg_data;
                idmc_pkg::CFG_MAX_PATTERN: r_cfg.max_pattern <= i_cfg_data;
                idmc_pkg::CFG_MIN_MILLIS: begin
                    r_cfg.min_millis <= i_cfg_data[idmc_pkg::MILLIS_W-1:0];
                end
                idmc_pkg::CFG_MAX_MILLIS: begin
                    r_cfg.max_millis <= i_cfg_data[idmc_pkg::MILLIS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // front: window check and leading-one search
    idmc_front u_front (
        .i_req     (i_req),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_work    (front_work)
    );

    // decoupling queue
    idmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_work)
    );

    // back: shifter and output register
    idmc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_work    (q_work),
        .o_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule
